// ===== design/pli_pkg.sv =====
// Package for the positional list block: widths, operation and status codes.
// No dependencies.
`default_nettype none
package pli_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int VALUE_W       = 32;
  localparam int POS_W         = 5;
  localparam int LEN_W         = 5;
  localparam int OP_W          = 2;
  localparam int ST_W          = 2;
  localparam int IN_TDATA_W    = 40;
  localparam int OUT_TDATA_W   = 40;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

endpackage
`default_nettype wire

// ===== design/pli_ram.sv =====
// List storage: one write port, one read port with registered read data.
// Depends on nothing but its parameters.
`default_nettype none
module pli_ram #(
  parameter int DEPTH  = 16,
  parameter int AW     = 4,
  parameter int DATA_W = 32
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [AW-1:0]     raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/positional_list_insert_delete_top.sv =====
// Top level of the positional list: sequencer, entry count and output register.
// Depends on pli_pkg and pli_ram.
//
// An ordered list of up to DEPTH signed 32-bit values held in a RAM with one
// write port and one registered read port. Insert and delete move entries one
// place per step, insert through the index decrementer and delete through the
// index incrementer, each step being a RAM read and a RAM write. A dump reads
// each entry and then outputs it before reading the next, waiting while the
// output is stalled. s_tready is high only while the sequencer is idle; a result
// waiting in the output register does not block the next word from being taken.
// The RAM has no reset and needs no clearing pass.
`default_nettype none
module positional_list_insert_delete_top
  import pli_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // value[31:0], position[36:32]
  input  wire logic [OP_W-1:0]        s_tuser,   // op[1:0]
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic      [OUT_TDATA_W-1:0] m_tdata,   // value_res[31:0], length[36:32]
  output logic      [ST_W-1:0]        m_tuser,   // status[1:0]
  output logic                        m_tlast
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int AW   = $clog2(DEPTH);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_DEL_RD,
    S_DEL_WR,
    S_DUMP_RD,
    S_DUMP_OUT,
    S_RESULT
  } state_t;

  state_t            state;
  logic [CW-1:0]     count;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     at;
  logic [VALUE_W-1:0] ins_value;
  status_t           res_status;

  logic [VALUE_W-1:0] in_value;
  logic [POS_W-1:0]  in_pos;
  logic [OP_W-1:0]   in_op;
  logic [CMPW-1:0]   pos_c;
  logic [CMPW-1:0]   cnt_c;
  logic [CW-1:0]     ins_at;
  logic [CW-1:0]     pos_idx;
  logic [CW-1:0]     idx_inc;
  logic [CW-1:0]     idx_dec;
  logic [CW-1:0]     cnt_dec;
  logic              out_free;
  logic              out_load;
  logic              in_take;
  logic [LEN_W-1:0]  len_out;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [VALUE_W-1:0] mem_rdata;

  assign in_value = s_tdata[VALUE_W-1:0];
  assign in_pos   = s_tdata[VALUE_W+POS_W-1:VALUE_W];
  assign in_op    = s_tuser;
  assign pos_c    = CMPW'(in_pos);
  assign cnt_c    = CMPW'(count);
  assign pos_idx  = CW'(pos_c - CMPW'(1));
  assign idx_inc  = idx + CW'(1);
  assign idx_dec  = idx - CW'(1);
  assign cnt_dec  = count - CW'(1);
  assign out_free = !m_tvalid || m_tready;
  assign out_load = out_free && (state == S_DUMP_OUT || state == S_RESULT);
  assign s_tready = (state == S_IDLE);
  assign in_take  = s_tvalid && s_tready;
  assign len_out  = LEN_W'(count);

  always_comb begin
    if (pos_c == CMPW'(1)) begin
      ins_at = '0;
    end else if (pos_c >= CMPW'(2) && pos_c <= cnt_c) begin
      ins_at = pos_idx;
    end else begin
      ins_at = count;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx[AW-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = idx[AW-1:0];
    unique case (state)
      S_INS_RD: mem_raddr = idx_dec[AW-1:0];
      S_INS_WR: mem_we = 1'b1;
      S_INS_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = at[AW-1:0];
        mem_wdata = ins_value;
      end
      S_DEL_RD: mem_raddr = idx_inc[AW-1:0];
      S_DEL_WR: mem_we = 1'b1;
      default: ;
    endcase
  end

  pli_ram #(
    .DEPTH  (DEPTH),
    .AW     (AW),
    .DATA_W (VALUE_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            ins_value  <= in_value;
            res_status <= ST_OK;
            state      <= S_RESULT;
            case (in_op)
              OP_INSERT: begin
                at  <= ins_at;
                idx <= count;
                if (count == CW'(DEPTH)) begin
                  res_status <= ST_FULL;
                end else if (count > ins_at) begin
                  state <= S_INS_RD;
                end else begin
                  state <= S_INS_PUT;
                end
              end
              OP_DELETE: begin
                idx <= pos_idx;
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                end else if (pos_c == '0 || pos_c > cnt_c) begin
                  res_status <= ST_RANGE;
                end else if (pos_c < cnt_c) begin
                  state <= S_DEL_RD;
                end else begin
                  count <= cnt_dec;
                end
              end
              OP_DUMP: begin
                idx <= '0;
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                end else begin
                  state <= S_DUMP_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_INS_RD: state <= S_INS_WR;
        S_INS_WR: begin
          idx <= idx_dec;
          state <= (idx_dec > at) ? S_INS_RD : S_INS_PUT;
        end
        S_INS_PUT: begin
          count <= count + CW'(1);
          state <= S_RESULT;
        end
        S_DEL_RD: state <= S_DEL_WR;
        S_DEL_WR: begin
          idx <= idx_inc;
          if (idx_inc < cnt_dec) begin
            state <= S_DEL_RD;
          end else begin
            count <= cnt_dec;
            state <= S_RESULT;
          end
        end
        S_DUMP_RD: state <= S_DUMP_OUT;
        S_DUMP_OUT: begin
          if (out_free) begin
            m_tdata  <= OUT_TDATA_W'({len_out, mem_rdata});
            m_tuser  <= ST_OK;
            m_tlast  <= (idx_inc == count);
            idx      <= idx_inc;
            state    <= (idx_inc == count) ? S_IDLE : S_DUMP_RD;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            m_tdata  <= OUT_TDATA_W'({len_out, {VALUE_W{1'b0}}});
            m_tuser  <= res_status;
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (count == $past(count) || count == $past(count) + CW'(1) ||
                     count == $past(count) - CW'(1)))
    else $error("entry count moved by more than one");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_EMPTY) |-> (m_tlast && m_tdata[VALUE_W-1:0] == '0))
    else $error("empty status without last or with data");

  a_busy_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS_WR || state == S_DEL_WR) |=> !$stable(idx))
    else $error("shift step did not move the index");

endmodule
`default_nettype wire

// ===== tb/tb_positional_list_insert_delete_top.sv =====
// Testbench for positional_list_insert_delete_top: directed table, then biased random ops,
// each accepted word checked against a queue-based list predictor.
// Depends on pli_pkg and the positional list RTL.
module tb_positional_list_insert_delete_top;
  import pli_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int               LIST_DEPTH   = DEPTH_DEFAULT;
  localparam logic [OP_W-1:0]  OP_SPARE     = 2'd3;
  localparam int               RANDOM_WORDS = 146;
  localparam int               SETTLE_CYCLES = 40;

  typedef struct {
    status_t                   status;
    logic signed [VALUE_W-1:0] value;
    logic [LEN_W-1:0]          length;
    logic                      last;
  } list_word_t;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   pos;
    int                 reps;
    bit                 typed;
    status_t            status;
    logic [LEN_W-1:0]   length;
  } stim_row_t;

  logic                   clk;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic [OP_W-1:0]        s_tuser  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [ST_W-1:0]        m_tuser;
  logic                   m_tlast;

  logic signed [VALUE_W-1:0] list_entries[$];
  list_word_t                pending_words[$];
  int                        mismatches = 0;
  bit                        no_idle = 1'b0;

  positional_list_insert_delete_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("Test completed with failures");
    $finish;
  end

  // Applies one op to the list copy; queues the words it produces when keep is set.
  task automatic apply_list_op(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] val,
                               input logic [POS_W-1:0] pos, input bit keep);
    list_word_t w;
    int         at;
    int         n;
    n = list_entries.size();
    w.value = '0;
    w.last  = 1'b1;
    w.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (n >= LIST_DEPTH) begin
          w.status = ST_FULL;
        end else begin
          if (n == 0 || pos == 1) at = 0;
          else if (pos >= 2 && pos <= n) at = pos - 1;
          else at = n;
          list_entries.insert(at, val);
        end
      end
      OP_DELETE: begin
        if (n == 0) w.status = ST_EMPTY;
        else if (pos == 0 || pos > n) w.status = ST_RANGE;
        else list_entries.delete(pos - 1);
      end
      OP_DUMP: begin
        if (n == 0) w.status = ST_EMPTY;
      end
      default: ;
    endcase
    w.length = LEN_W'(list_entries.size());
    if (!keep) return;
    if (op == OP_DUMP && n != 0) begin
      for (int k = 0; k < n; k++) begin
        w.value = list_entries[k];
        w.last  = (k == n - 1);
        pending_words.push_back(w);
      end
    end else begin
      pending_words.push_back(w);
    end
  endtask

  task automatic send_word(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] val,
                           input logic [POS_W-1:0] pos);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, pos, val};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic note_mismatch(input string msg);
    if (mismatches < 10) $display("%t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Receiver: random stall before each word, with stretches of none.
  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin
    list_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_words.size() == 0) begin
        note_mismatch($sformatf("unexpected word: status %0d value %0h length %0d last %0b",
                                m_tuser, m_tdata[31:0], m_tdata[36:32], m_tlast));
      end else begin
        want = pending_words.pop_front();
        if (m_tuser !== want.status || m_tdata[31:0] !== want.value ||
            m_tdata[36:32] !== want.length || m_tlast !== want.last)
          note_mismatch($sformatf({"word mismatch: exp status %0d value %0h length %0d ",
                                   "last %0b, got status %0d value %0h length %0d last %0b"},
                                  want.status, want.value, want.length, want.last,
                                  m_tuser, m_tdata[31:0], m_tdata[36:32], m_tlast));
      end
    end
  end

  initial begin
    stim_row_t          dir_table [0:22];
    list_word_t         typed_word;
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] val;
    logic [POS_W-1:0]   pos;
    int                 pick;
    bit                 filling;

    dir_table = '{
      '{OP_DUMP,   32'h0000_0000, 5'd0,  1, 1'b1, ST_EMPTY, 5'd0},
      '{OP_DELETE, 32'h0000_0000, 5'd1,  1, 1'b1, ST_EMPTY, 5'd0},
      '{OP_SPARE,  32'hFFFF_FFFF, 5'd31, 1, 1'b1, ST_OK,    5'd0},
      '{OP_INSERT, 32'h7FFF_FFFF, 5'd7,  1, 1'b1, ST_OK,    5'd1},
      '{OP_INSERT, 32'h8000_0000, 5'd1,  1, 1'b1, ST_OK,    5'd2},
      '{OP_INSERT, 32'hFFFF_FFFF, 5'd0,  1, 1'b1, ST_OK,    5'd3},
      '{OP_INSERT, 32'h0000_0000, 5'd31, 1, 1'b1, ST_OK,    5'd4},
      '{OP_INSERT, 32'h5555_5555, 5'd2,  1, 1'b0, ST_OK,    5'd0},
      '{OP_INSERT, 32'hAAAA_AAAA, 5'd3,  1, 1'b0, ST_OK,    5'd0},
      '{OP_DELETE, 32'h0000_0000, 5'd0,  1, 1'b1, ST_RANGE, 5'd6},
      '{OP_DELETE, 32'h0000_0000, 5'd31, 1, 1'b1, ST_RANGE, 5'd6},
      '{OP_DELETE, 32'h0000_0000, 5'd7,  1, 1'b1, ST_RANGE, 5'd6},
      '{OP_DUMP,   32'h0000_0000, 5'd0,  1, 1'b0, ST_OK,    5'd0},
      '{OP_DELETE, 32'h0000_0000, 5'd6,  1, 1'b0, ST_OK,    5'd0},
      '{OP_DELETE, 32'h0000_0000, 5'd1,  1, 1'b0, ST_OK,    5'd0},
      '{OP_INSERT, 32'h1234_5678, 5'd2, 12, 1'b0, ST_OK,    5'd0},
      '{OP_INSERT, 32'hDEAD_BEEF, 5'd1,  1, 1'b1, ST_FULL,  5'd16},
      '{OP_DUMP,   32'h0000_0000, 5'd0,  1, 1'b0, ST_OK,    5'd0},
      '{OP_SPARE,  32'h0000_0000, 5'd0,  1, 1'b1, ST_OK,    5'd16},
      '{OP_DELETE, 32'h0000_0000, 5'd16, 1, 1'b0, ST_OK,    5'd0},
      '{OP_DELETE, 32'h0000_0000, 5'd17, 1, 1'b1, ST_RANGE, 5'd15},
      '{OP_INSERT, 32'h0F0F_0F0F, 5'd15, 1, 1'b0, ST_OK,    5'd0},
      '{OP_DUMP,   32'h0000_0000, 5'd0,  1, 1'b0, ST_OK,    5'd0}
    };

    rst <= 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_table[i]) begin
      for (int r = 0; r < dir_table[i].reps; r++) begin
        send_word(dir_table[i].op, dir_table[i].value, dir_table[i].pos);
        apply_list_op(dir_table[i].op, dir_table[i].value, dir_table[i].pos,
                      !dir_table[i].typed);
        if (dir_table[i].typed) begin
          typed_word = '{dir_table[i].status, '0, dir_table[i].length, 1'b1};
          pending_words.push_back(typed_word);
        end
      end
    end

    // Alternate fill and drain phases so the list hits both full and empty.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      filling = ((n / 30) % 2) == 0;
      no_idle = (n >= 40 && n < 60) || (n >= 120 && n < 140);
      if (n == 90) begin
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < (filling ? 60 : 25)) op = OP_INSERT;
      else if (pick < 82) op = OP_DELETE;
      else if (pick < 96) op = OP_DUMP;
      else op = OP_SPARE;
      case ($urandom_range(0, 9))
        0: val = 32'h8000_0000;
        1: val = 32'h7FFF_FFFF;
        2: val = 32'hFFFF_FFFF;
        default: val = $urandom();
      endcase
      if ($urandom_range(0, 3) == 0) pos = POS_W'($urandom_range(0, 31));
      else pos = POS_W'($urandom_range(0, list_entries.size() + 1));
      send_word(op, val, pos);
      apply_list_op(op, val, pos, 1'b1);
    end
    s_tvalid <= 1'b0;
    no_idle = 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/pli_pkg.sv
design/pli_ram.sv
design/positional_list_insert_delete_top.sv
tb/tb_positional_list_insert_delete_top.sv
